[rtl/near_plane_polygon_clip_defines.svh]
// Assertion macros for the near-plane polygon clipper
`ifndef NEAR_PLANE_POLYGON_CLIP_DEFINES_SVH
`define NEAR_PLANE_POLYGON_CLIP_DEFINES_SVH
`ifndef SYNTHESIS
`define NPC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define NPC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define NPC_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define NPC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

[rtl/npc_pkg.sv]
// Types and constants shared by the near-plane clipper
`default_nettype none
package npc_pkg;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned NEAR_W = 31;
   localparam int unsigned FRAC_BITS = 30;
   localparam logic [NEAR_W-1:0] NEAR_RESET = 31'd524288;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] tex_u;
      logic signed [COORD_W-1:0] tex_v;
      logic                      last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic signed [COORD_W-1:0] out_u;
      logic signed [COORD_W-1:0] out_v;
      logic                      last_of_polygon;
      logic                      polygon_empty;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic store_wr;      // write request into store
      logic load_pair;     // read entries cur and prev into work regs
      logic div_start;     // start fraction divide
      logic lerp_step;     // advance interpolation one phase (multiply or add)
      logic emit_cross;    // load output reg with intersection
      logic emit_vert;     // load output reg with current vertex
      logic emit_empty;    // load output reg with empty marker
      logic set_last;      // mark loaded result as last
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cur_in;
      logic prev_in;
      logic div_done;
      logic lerp_done;
      logic req_in;        // incoming vertex lies inside
   } sts_type;
endpackage
`default_nettype wire

[rtl/npc_stream_if.sv]
// Valid/ready channel carrying one payload
`default_nettype none
interface npc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/npc_datapath.sv]
// Vertex store, fraction divider, interpolator and output register
`default_nettype none
module npc_datapath #(
   parameter int unsigned MaxVertices = 8,
   parameter int unsigned IdxW = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire npc_pkg::cmd_type              cmd,
   output npc_pkg::sts_type                   sts,
   input  wire npc_pkg::req_type              req_data,
   input  wire logic [IdxW-1:0]               wr_idx,
   input  wire logic [IdxW-1:0]               cur_idx,
   input  wire logic [IdxW-1:0]               prev_idx,
   input  wire logic [npc_pkg::NEAR_W-1:0]    near_z,
   output npc_pkg::rsp_type                   rsp_data
);
   localparam int unsigned CW = npc_pkg::COORD_W;

   // vertex store: x,y,z,u,v per entry
   logic [5*CW-1:0] mem [MaxVertices];
   logic [5*CW-1:0] cur_ff, prev_ff;

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         mem[wr_idx] <= {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                         req_data.tex_u, req_data.tex_v};
      end
      if (cmd.load_pair) begin
         cur_ff  <= mem[cur_idx];
         prev_ff <= mem[prev_idx];
      end
   end

   // signed inside tests against the near plane
   logic signed [CW-1:0] cur_z, prev_z;
   logic signed [CW:0]   near_s;
   assign cur_z  = cur_ff[2*CW +: CW];
   assign prev_z = prev_ff[2*CW +: CW];
   assign near_s = {2'b00, near_z};
   assign sts.cur_in  = $signed({cur_z[CW-1], cur_z}) >= near_s;
   assign sts.prev_in = $signed({prev_z[CW-1], prev_z}) >= near_s;
   assign sts.req_in  = $signed({req_data.pos_z[CW-1], req_data.pos_z}) >= near_s;

   // inside / outside selection
   logic [5*CW-1:0] in_v, out_v;
   assign in_v  = sts.cur_in ? cur_ff : prev_ff;
   assign out_v = sts.cur_in ? prev_ff : cur_ff;

   // restoring divider: f = floor(a * 2^30 / d), one quotient bit a cycle
   localparam int unsigned DW = CW + 2;
   localparam int unsigned QB = npc_pkg::FRAC_BITS;
   logic [DW-1:0] rem_ff, rem_in, den_ff, trial;
   logic [QB-1:0] quo_ff, quo_in;
   logic [5:0]    dcnt_ff, dcnt_in;
   logic          dbusy_ff, dbusy_in;
   logic signed [DW-1:0] a_w, d_w;
   assign a_w = DW'(signed'(in_v[2*CW +: CW])) - DW'(near_z);
   assign d_w = DW'(signed'(in_v[2*CW +: CW])) - DW'(signed'(out_v[2*CW +: CW]));
   assign trial = {rem_ff[DW-2:0], 1'b0} - den_ff;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff; dbusy_in = dbusy_ff;
      if (cmd.div_start) begin
         rem_in = (a_w > 0 && d_w > 0) ? a_w : '0;
         quo_in = '0; dcnt_in = 6'(QB); dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         if (!trial[DW-1]) begin
            rem_in = trial; quo_in = {quo_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW-2:0], 1'b0}; quo_in = {quo_ff[QB-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 6'd1;
         dbusy_in = dcnt_ff != 6'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0; dcnt_ff <= '0;
      end else begin
         dbusy_ff <= dbusy_in; dcnt_ff <= dcnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in;
      if (cmd.div_start) den_ff <= d_w;
   end
   assign sts.div_done = !dbusy_ff;

   // interpolation: each coordinate takes a multiply phase, then an add phase
   logic [2:0] lsel_ff, lsel_in;
   logic       lph_ff, lph_in;
   logic signed [63:0] prod_ff;
   logic signed [CW-1:0] lres_ff [4];
   logic signed [CW-1:0] lin, lout;
   logic signed [CW:0]   delta;
   logic signed [63:0]   qv;
   logic signed [CW+1:0] sumv;
   logic signed [CW-1:0] satv;
   always_comb begin
      unique case (lsel_ff)
         3'd0: begin lin = in_v[4*CW +: CW]; lout = out_v[4*CW +: CW]; end
         3'd1: begin lin = in_v[3*CW +: CW]; lout = out_v[3*CW +: CW]; end
         3'd2: begin lin = in_v[CW +: CW];   lout = out_v[CW +: CW];   end
         default: begin lin = in_v[0 +: CW]; lout = out_v[0 +: CW];   end
      endcase
      delta = {lout[CW-1], lout} - {lin[CW-1], lin};
      qv    = prod_ff >>> QB;
      sumv  = {{2{lin[CW-1]}}, lin} + (CW+2)'(qv);
      if (sumv > (CW+2)'(64'sh7FFFFFFF))       satv = 32'sh7FFFFFFF;
      else if (sumv < -(CW+2)'(64'sh80000000)) satv = 32'sh80000000;
      else satv = sumv[CW-1:0];
   end
   always_comb begin
      lsel_in = lsel_ff; lph_in = lph_ff;
      if (cmd.div_start) begin
         lsel_in = '0; lph_in = 1'b0;
      end else if (cmd.lerp_step) begin
         lph_in = !lph_ff;
         if (lph_ff) lsel_in = lsel_ff + 3'd1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         lsel_ff <= '0; lph_ff <= 1'b0;
      end else begin
         lsel_ff <= lsel_in; lph_ff <= lph_in;
      end
      if (cmd.lerp_step && !lph_ff)
         prod_ff <= $signed({1'b0, quo_ff}) * delta;
      if (cmd.lerp_step && lph_ff)
         lres_ff[lsel_ff[1:0]] <= satv;
   end
   assign sts.lerp_done = lsel_ff == 3'd4;

   // output register
   npc_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.emit_cross) begin
         rsp_ff <= '{lres_ff[0], lres_ff[1], CW'(near_z), lres_ff[2], lres_ff[3],
                     cmd.set_last, 1'b0};
      end else if (cmd.emit_vert) begin
         rsp_ff <= '{cur_ff[4*CW +: CW], cur_ff[3*CW +: CW], cur_ff[2*CW +: CW],
                     cur_ff[CW +: CW], cur_ff[0 +: CW], cmd.set_last, 1'b0};
      end else if (cmd.emit_empty) begin
         rsp_ff <= '{'0, '0, '0, '0, '0, 1'b1, 1'b1};
      end
   end
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

[rtl/npc_control.sv]
// Sequencer that loads vertices and walks the clip loop
`default_nettype none
module npc_control #(
   parameter int unsigned MaxVertices = 8,
   parameter int unsigned IdxW = 3
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_last,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire npc_pkg::sts_type sts,
   output npc_pkg::cmd_type     cmd,
   output logic [IdxW-1:0]      wr_idx,
   output logic [IdxW-1:0]      cur_idx,
   output logic [IdxW-1:0]      prev_idx
);
   typedef enum logic [7:0] {
      ST_LOAD  = 8'b0000_0001,
      ST_READ  = 8'b0000_0010,
      ST_TEST  = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_LERP  = 8'b0001_0000,
      ST_XOUT  = 8'b0010_0000,
      ST_VOUT  = 8'b0100_0000,
      ST_EOUT  = 8'b1000_0000
   } state_type;

   localparam int unsigned CntW = IdxW + 1;
   state_type      state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in, n_ff, n_in, i_ff, i_in;
   // one past the index of the last stored inside vertex, zero if none
   logic [CntW-1:0] lin_ff, lin_in;
   logic            any_ff, any_in, rv_ff, rv_in;
   logic            accept, last_i, emit_now;

   assign accept = req_valid && req_ready;
   assign req_ready = state_ff == ST_LOAD;
   assign wr_idx = cnt_ff[IdxW-1:0];
   assign cur_idx = i_ff[IdxW-1:0];
   assign prev_idx = (i_ff == '0) ? IdxW'(n_ff - 1'b1) : IdxW'(i_ff - 1'b1);
   assign last_i = i_ff == n_ff - 1'b1;
   assign rsp_valid = rv_ff;
   assign emit_now = !rv_ff || rsp_ready;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; n_in = n_ff; i_in = i_ff;
      lin_in = lin_ff;
      any_in = any_ff; rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < CntW'(MaxVertices)) begin
                  cmd.store_wr = 1'b1; cnt_in = cnt_ff + 1'b1;
                  if (sts.req_in) lin_in = cnt_in;
                  else if (cnt_ff == '0) lin_in = '0;
               end
               if (req_last) begin
                  n_in = cnt_in; i_in = '0; any_in = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.load_pair = 1'b1; state_in = ST_TEST;
         end
         ST_TEST: begin
            if (sts.cur_in != sts.prev_in) begin
               cmd.div_start = 1'b1; state_in = ST_DIV;
            end else if (sts.cur_in) state_in = ST_VOUT;
            else if (!last_i) begin
               i_in = i_ff + 1'b1; state_in = ST_READ;
            end else if (any_ff) begin
               cnt_in = '0; state_in = ST_LOAD;
            end else state_in = ST_EOUT;
         end
         ST_DIV: if (sts.div_done) state_in = ST_LERP;
         ST_LERP: begin
            if (sts.lerp_done) state_in = ST_XOUT;
            else cmd.lerp_step = 1'b1;
         end
         ST_XOUT: if (emit_now) begin
            cmd.emit_cross = 1'b1; rv_in = 1'b1; any_in = 1'b1;
            // leaving crossing is last when no inside vertex follows
            cmd.set_last = !sts.cur_in && lin_ff <= i_ff + 1'b1;
            if (sts.cur_in) state_in = ST_VOUT;
            else if (!last_i) begin
               i_in = i_ff + 1'b1; state_in = ST_READ;
            end else begin
               cnt_in = '0; state_in = ST_LOAD;
            end
         end
         ST_VOUT: if (emit_now) begin
            cmd.emit_vert = 1'b1; rv_in = 1'b1; any_in = 1'b1;
            cmd.set_last = last_i;
            if (!last_i) begin
               i_in = i_ff + 1'b1; state_in = ST_READ;
            end else begin
               cnt_in = '0; state_in = ST_LOAD;
            end
         end
         ST_EOUT: if (emit_now) begin
            cmd.emit_empty = 1'b1; rv_in = 1'b1;
            cnt_in = '0; state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; cnt_ff <= '0; n_ff <= '0; i_ff <= '0;
         lin_ff <= '0; any_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; n_ff <= n_in; i_ff <= i_in;
         lin_ff <= lin_in; any_ff <= any_in; rv_ff <= rv_in;
      end
   end
endmodule
`default_nettype wire

[rtl/near_plane_polygon_clip.sv]
// Near-plane polygon clipper: vertices transfer in one per cycle while the block
// is loading; after the last vertex each edge is read and tested, a crossing edge
// adds a divide, an interpolation and an emit, and an inside vertex adds an emit;
// an empty polygon adds its marker. A stalled result holds the loop.
// No input is taken while a polygon is being clipped.
// Synchronous active-high reset clears control state and sets near to 524288 (raw).
`default_nettype none
`include "near_plane_polygon_clip_defines.svh"
module near_plane_polygon_clip #(
   parameter int unsigned MAX_VERTICES = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   npc_stream_if.sink                      req,
   npc_stream_if.source                    rsp,
   input  wire logic                       csr_we,
   input  wire logic [npc_pkg::NEAR_W-1:0] csr_wdata
);
   localparam int unsigned IdxW = $clog2(MAX_VERTICES);

   // near plane register
   logic [npc_pkg::NEAR_W-1:0] near_ff;
   always_ff @(posedge clock) begin
      if (reset) near_ff <= npc_pkg::NEAR_RESET;
      else if (csr_we) near_ff <= csr_wdata;
   end

   npc_pkg::cmd_type cmd;
   npc_pkg::sts_type sts;
   npc_pkg::req_type req_data;
   npc_pkg::rsp_type rsp_data;
   logic [IdxW-1:0] wr_idx, cur_idx, prev_idx;
   assign req_data = req.payload;
   assign rsp.payload = rsp_data;

   npc_control #(.MaxVertices(MAX_VERTICES), .IdxW(IdxW)) u_ctl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .req_last(req_data.last_vertex), .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready), .sts, .cmd, .wr_idx, .cur_idx, .prev_idx);

   npc_datapath #(.MaxVertices(MAX_VERTICES), .IdxW(IdxW)) u_dp (
      .clock, .reset, .cmd, .sts, .req_data, .wr_idx, .cur_idx, .prev_idx,
      .near_z(near_ff), .rsp_data);

   `NPC_ASSERT_IMPLY(a_emit_one, clock, reset, 1'b1,
      $countones({cmd.emit_cross, cmd.emit_vert, cmd.emit_empty}) <= 1)
   `NPC_ASSERT_IMPLY(a_no_overrun, clock, reset, rsp.valid && !rsp.ready,
      !(cmd.emit_cross || cmd.emit_vert || cmd.emit_empty))
   `NPC_ASSERT_NEXT(a_empty_last, clock, reset, cmd.emit_empty,
      rsp.payload.last_of_polygon && rsp.valid)
endmodule
`default_nettype wire
